@@ hw/rtl/vigenere_char_cipher_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef VIGENERE_CHAR_CIPHER_UNIT_MACROS_SVH
`define VIGENERE_CHAR_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define VCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define VCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs during reset.
`define VCC_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/vcc_pkg.sv @@
package vcc_pkg;

   localparam int CP_W        = 21;
   localparam int CP_BYTES_W  = 24;
   localparam int KEY_W       = 6;
   localparam int KEY_WORD_W  = 60;
   localparam int KEY_WORDS   = 4;
   localparam int KEYS_PER_WORD = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int MAX_KEY_LENGTH = 40;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [KEY_W-1:0] ENG_SIZE = KEY_W'(26);
   localparam logic [KEY_W-1:0] RUS_SIZE = KEY_W'(33);
   localparam logic [KEY_W-1:0] RUS_IO_IDX = KEY_W'(6);

   localparam logic [CP_W-1:0] ENG_LOWER_A = CP_W'(21'h61);
   localparam logic [CP_W-1:0] ENG_LOWER_Z = CP_W'(21'h7A);
   localparam logic [CP_W-1:0] ENG_UPPER_A = CP_W'(21'h41);
   localparam logic [CP_W-1:0] ENG_UPPER_Z = CP_W'(21'h5A);
   localparam logic [CP_W-1:0] RUS_UPPER_FIRST = CP_W'(21'h410);
   localparam logic [CP_W-1:0] RUS_UPPER_LAST  = CP_W'(21'h42F);
   localparam logic [CP_W-1:0] RUS_UPPER_IO    = CP_W'(21'h401);
   localparam logic [CP_W-1:0] RUS_LOWER_FIRST = CP_W'(21'h430);
   localparam logic [CP_W-1:0] RUS_LOWER_IE    = CP_W'(21'h435);
   localparam logic [CP_W-1:0] RUS_LOWER_ZHE   = CP_W'(21'h436);
   localparam logic [CP_W-1:0] RUS_LOWER_LAST  = CP_W'(21'h44F);
   localparam logic [CP_W-1:0] RUS_LOWER_IO    = CP_W'(21'h451);
   localparam logic [CP_W-1:0] RUS_CASE_DELTA  = CP_W'(21'h20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTION  = 3'd0,
      CSR_LANGUAGE   = 3'd1,
      CSR_KEY_LENGTH = 3'd2,
      CSR_KEY_WORD_0 = 3'd3,
      CSR_KEY_WORD_1 = 3'd4,
      CSR_KEY_WORD_2 = 3'd5,
      CSR_KEY_WORD_3 = 3'd6
   } vcc_csr_index_type;

   typedef struct packed {
      logic                                 decrypt;
      logic                                 russian;
      logic [KEY_W-1:0]                     key_length;
      logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_words;
   } vcc_cfg_type;

   // One classified item as it waits between front and back.
   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic             last;
      logic             is_letter;
      logic             upper;
      logic [KEY_W-1:0] index;
      logic [KEY_W-1:0] key;
   } vcc_item_type;

   function automatic logic [KEY_W-1:0] alpha_size(input logic russian);
      return russian ? RUS_SIZE : ENG_SIZE;
   endfunction

endpackage

@@ hw/rtl/vigenere_char_cipher_unit.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: code_point; tlast: last_of_message
// rsp       out        rsp_tvalid/rsp_tready  tdata: out_code_point; tlast: out_last
// csr       in         csr_valid/csr_ready    csr_index, csr_data (write only)
//
// One character per cycle sustained while rsp_tready is high. After the req accept
// the item passes a queue slot, then the output register, which raises rsp_tvalid.
// The key position register in the front is the only loop: it updates at the
// accept edge, so back-to-back characters see the right key letter.
// Sync active-high reset: key position 0, queue empty, rsp idle, key length 1, rest 0.
// A stalled rsp fills the two-entry queue; req_tready drops only when it is full.
module vigenere_char_cipher_unit #(
   parameter int MAX_KEY_LENGTH = vcc_pkg::MAX_KEY_LENGTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [20:0] code_point, [23:21] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vcc_pkg::CP_BYTES_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   // rsp_tdata: [20:0] out_code_point, [23:21] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vcc_pkg::CP_BYTES_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vcc_pkg::KEY_WORD_W-1:0]    csr_data
);
   import vcc_pkg::*;

   vcc_cfg_type  cfg_ff, cfg_in;
   vcc_item_type push_item, head;
   logic         push, pop, full, not_empty;
   logic [CP_W-1:0] out_cp;

   // Config registers; always ready, unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIRECTION:  cfg_in.decrypt      = csr_data[0];
            CSR_LANGUAGE:   cfg_in.russian      = csr_data[0];
            CSR_KEY_LENGTH: cfg_in.key_length   = csr_data[KEY_W-1:0];
            CSR_KEY_WORD_0: cfg_in.key_words[0] = csr_data;
            CSR_KEY_WORD_1: cfg_in.key_words[1] = csr_data;
            CSR_KEY_WORD_2: cfg_in.key_words[2] = csr_data;
            CSR_KEY_WORD_3: cfg_in.key_words[3] = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{decrypt: 1'b0, russian: 1'b0, key_length: KEY_W'(1), key_words: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify and pick the key letter.
   vcc_front #(
      .MAX_KEY_LENGTH (MAX_KEY_LENGTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_code_point (req_tdata[CP_W-1:0]),
      .in_last       (req_tlast),
      .push          (push),
      .push_item     (push_item),
      .queue_full    (full)
   );

   vcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   // Back: shift, rebuild the code point, hold it in the output register.
   vcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_not_empty    (not_empty),
      .q_head         (head),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_code_point (out_cp),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {(CP_BYTES_W-CP_W)'(0), out_cp};

endmodule

@@ hw/rtl/vcc_front.sv @@
module vcc_front #(
   parameter int MAX_KEY_LENGTH = vcc_pkg::MAX_KEY_LENGTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vcc_pkg::vcc_cfg_type      cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [vcc_pkg::CP_W-1:0]  in_code_point,
   input  logic                      in_last,
   output logic                      push,
   output vcc_pkg::vcc_item_type     push_item,
   input  logic                      queue_full
);
   import vcc_pkg::*;

   logic [KEY_W-1:0] key_position_ff, key_position_in;
   logic [CP_W-1:0]  lc_cp;
   logic             hit, upper;
   logic [KEY_W-1:0] idx, n, len, kp_inc, key_raw, key_red;
   logic [1:0]       word_sel;
   logic [3:0]       digit;
   logic [KEY_WORD_W-1:0] word;
   logic             accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign n        = alpha_size(cfg.russian);

   // Classify: letter or not, case, alphabet index.
   always_comb begin
      hit   = 1'b0;
      upper = 1'b0;
      idx   = '0;
      lc_cp = in_code_point;
      if (!cfg.russian) begin
         if (in_code_point >= ENG_LOWER_A && in_code_point <= ENG_LOWER_Z) begin
            hit = 1'b1;
            idx = KEY_W'(in_code_point - ENG_LOWER_A);
         end else if (in_code_point >= ENG_UPPER_A && in_code_point <= ENG_UPPER_Z) begin
            hit   = 1'b1;
            upper = 1'b1;
            idx   = KEY_W'(in_code_point - ENG_UPPER_A);
         end
      end else begin
         if (in_code_point >= RUS_UPPER_FIRST && in_code_point <= RUS_UPPER_LAST) begin
            upper = 1'b1;
            lc_cp = in_code_point + RUS_CASE_DELTA;
         end else if (in_code_point == RUS_UPPER_IO) begin
            upper = 1'b1;
            lc_cp = RUS_LOWER_IO;
         end
         if (lc_cp >= RUS_LOWER_FIRST && lc_cp <= RUS_LOWER_IE) begin
            hit = 1'b1;
            idx = KEY_W'(lc_cp - RUS_LOWER_FIRST);
         end else if (lc_cp == RUS_LOWER_IO) begin
            hit = 1'b1;
            idx = RUS_IO_IDX;
         end else if (lc_cp >= RUS_LOWER_ZHE && lc_cp <= RUS_LOWER_LAST) begin
            hit = 1'b1;
            idx = KEY_W'(lc_cp - RUS_LOWER_FIRST) + KEY_W'(1);
         end
      end
   end

   // Key letter at the current position, reduced below the alphabet size.
   always_comb begin
      if (key_position_ff >= KEY_W'(3 * KEYS_PER_WORD))      word_sel = 2'd3;
      else if (key_position_ff >= KEY_W'(2 * KEYS_PER_WORD)) word_sel = 2'd2;
      else if (key_position_ff >= KEY_W'(KEYS_PER_WORD))     word_sel = 2'd1;
      else                                                   word_sel = 2'd0;
      digit   = 4'(key_position_ff - KEY_W'(word_sel) * KEY_W'(KEYS_PER_WORD));
      word    = cfg.key_words[word_sel];
      key_raw = word[digit * KEY_W +: KEY_W];
      if ({1'b0, key_raw} >= {n, 1'b0})  key_red = key_raw - {n[KEY_W-2:0], 1'b0};
      else if (key_raw >= n)             key_red = key_raw - n;
      else                               key_red = key_raw;
   end

   // Key position advance with wrap at the clamped length.
   always_comb begin
      if (cfg.key_length == '0)                             len = KEY_W'(1);
      else if (cfg.key_length > KEY_W'(MAX_KEY_LENGTH))     len = KEY_W'(MAX_KEY_LENGTH);
      else                                                  len = cfg.key_length;
      kp_inc          = key_position_ff + KEY_W'(1);
      key_position_in = key_position_ff;
      if (accept) begin
         if (hit) key_position_in = (kp_inc >= len) ? '0 : kp_inc;
         if (in_last) key_position_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) key_position_ff <= '0;
      else       key_position_ff <= key_position_in;
   end

   assign push                 = accept;
   assign push_item.code_point = in_code_point;
   assign push_item.last       = in_last;
   assign push_item.is_letter  = hit;
   assign push_item.upper      = upper;
   assign push_item.index      = idx;
   assign push_item.key        = key_red;

endmodule

@@ hw/rtl/vcc_queue.sv @@
module vcc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vcc_pkg::vcc_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output vcc_pkg::vcc_item_type head
);
   import vcc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   vcc_item_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + (PTR_W+1)'(1);
      else if (pop && !push) count_in = count_ff - (PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ hw/rtl/vcc_back.sv @@
module vcc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  vcc_pkg::vcc_cfg_type      cfg,
   input  logic                      q_not_empty,
   input  vcc_pkg::vcc_item_type     q_head,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [vcc_pkg::CP_W-1:0]  out_code_point,
   output logic                      out_last
);
   import vcc_pkg::*;

   logic             out_valid_ff, out_valid_in;
   logic [CP_W-1:0]  out_cp_ff, out_cp_in;
   logic             out_last_ff;
   logic [KEY_W-1:0] n, shifted, adj;
   logic [KEY_W:0]   sum;

   assign n   = alpha_size(cfg.russian);
   assign pop = q_not_empty && (!out_valid_ff || out_ready);

   // Shift the index by the key letter, mod alphabet size.
   always_comb begin
      if (cfg.decrypt) sum = {1'b0, q_head.index} + {1'b0, n} - {1'b0, q_head.key};
      else             sum = {1'b0, q_head.index} + {1'b0, q_head.key};
      shifted = (sum >= {1'b0, n}) ? KEY_W'(sum - {1'b0, n}) : KEY_W'(sum);
      adj     = (shifted < RUS_IO_IDX) ? shifted : shifted - KEY_W'(1);
      if (!q_head.is_letter) begin
         out_cp_in = q_head.code_point;
      end else if (!cfg.russian) begin
         out_cp_in = (q_head.upper ? ENG_UPPER_A : ENG_LOWER_A) + CP_W'(shifted);
      end else if (shifted == RUS_IO_IDX) begin
         out_cp_in = q_head.upper ? RUS_UPPER_IO : RUS_LOWER_IO;
      end else begin
         out_cp_in = (q_head.upper ? RUS_UPPER_FIRST : RUS_LOWER_FIRST) + CP_W'(adj);
      end
      out_valid_in = pop || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_cp_ff   <= out_cp_in;
         out_last_ff <= q_head.last;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_code_point = out_cp_ff;
   assign out_last       = out_last_ff;

endmodule

@@ hw/rtl/vcc_checker.sv @@
`include "vigenere_char_cipher_unit_macros.svh"

module vcc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vcc_pkg::CP_BYTES_W-1:0]    rsp_tdata,
   input logic                              rsp_tlast
);
   import vcc_pkg::*;

   // a stalled item holds
   `VCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed under stall")

   // reset leaves the queue empty and the output idle
   `VCC_ASSERT_NEXT_ANY(a_reset_idle, clock, reset,
      !rsp_tvalid && req_tready, "not idle after reset")

   // queue can only fill while the output register holds an item
   `VCC_ASSERT_NOW(a_full_implies_out, clock, reset, !req_tready,
      rsp_tvalid, "req stalled with empty output")

   // padding bits above the code point stay zero
   `VCC_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid,
      rsp_tdata[CP_BYTES_W-1:CP_W] == '0, "rsp padding not zero")

endmodule

bind vigenere_char_cipher_unit vcc_checker u_vcc_checker (.*);

@@ bench/vigenere_char_cipher_unit_test.sv @@
`timescale 1ns / 1ps

module vigenere_char_cipher_unit_test;
   import vcc_pkg::*;

   // Code points the cipher cares about.
   localparam logic [CP_W-1:0] LAT_A_LO  = 21'h61;
   localparam logic [CP_W-1:0] LAT_Z_LO  = 21'h7A;
   localparam logic [CP_W-1:0] LAT_A_UP  = 21'h41;
   localparam logic [CP_W-1:0] LAT_Z_UP  = 21'h5A;
   localparam logic [CP_W-1:0] CYR_A_UP  = 21'h410;
   localparam logic [CP_W-1:0] CYR_YA_UP = 21'h42F;
   localparam logic [CP_W-1:0] CYR_IO_UP = 21'h401;
   localparam logic [CP_W-1:0] CYR_A_LO  = 21'h430;
   localparam logic [CP_W-1:0] CYR_IE_LO = 21'h435;
   localparam logic [CP_W-1:0] CYR_ZH_LO = 21'h436;
   localparam logic [CP_W-1:0] CYR_YA_LO = 21'h44F;
   localparam logic [CP_W-1:0] CYR_IO_LO = 21'h451;
   localparam logic [CP_W-1:0] CYR_CASE  = 21'h20;
   localparam int              IO_SLOT   = 6;   // io sits right after ie
   localparam int              LAT_SIZE  = 26;
   localparam int              CYR_SIZE  = 33;

   // Index the block has no register for; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam int RANDOM_PHASES    = 12;
   localparam int ITEMS_PER_PHASE  = 73;
   localparam int SETTLE_CYCLES    = 4;        // pipeline drain plus margin
   localparam int TIMEOUT_CYCLES   = 400_000;

   typedef struct {
      logic [CP_W-1:0] code_point;
      logic            last;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CP_BYTES_W-1:0]  req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CP_BYTES_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [KEY_WORD_W-1:0]  csr_data = '0;

   // Predictor copy of the register file and the key position.
   logic                   cfg_decrypt = 1'b0;
   logic                   cfg_russian = 1'b0;
   logic [KEY_W-1:0]       cfg_key_length = KEY_W'(1);
   logic [KEY_WORD_W-1:0]  cfg_key_words [KEY_WORDS] = '{default: '0};
   logic [KEY_W-1:0]       key_pos = '0;

   char_item_type pending_chars[$];    // waiting for the driver
   char_item_type expected_chars[$];   // accepted, result not yet seen

   int   req_wait = 0;
   int   rsp_hold = 0;
   logic steady = 1'b0;                // phase without any idling
   int   failures = 0;

   vigenere_char_cipher_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   // Alphabet index -> code point; io/IO are out of line in Cyrillic.
   function automatic logic [CP_W-1:0] letter_code(input int idx, input logic russian,
                                                   input logic upper);
      if (!russian)
         return (upper ? LAT_A_UP : LAT_A_LO) + CP_W'(idx);
      if (idx == IO_SLOT)
         return upper ? CYR_IO_UP : CYR_IO_LO;
      return (upper ? CYR_A_UP : CYR_A_LO) + CP_W'(idx < IO_SLOT ? idx : idx - 1);
   endfunction

   // Ciphers one character under the current settings and steps the key position.
   function automatic logic [CP_W-1:0] cipher_char(input logic [CP_W-1:0] cp,
                                                   input logic last);
      logic            upper;
      logic [CP_W-1:0] folded;
      logic [CP_W-1:0] res;
      int              idx;
      int              size;
      int              len;
      int              kp;
      int              shift;
      upper = 1'b0;
      idx   = -1;
      res   = cp;
      size  = cfg_russian ? CYR_SIZE : LAT_SIZE;
      if (!cfg_russian) begin
         if (cp >= LAT_A_LO && cp <= LAT_Z_LO) begin
            idx = int'(cp - LAT_A_LO);
         end else if (cp >= LAT_A_UP && cp <= LAT_Z_UP) begin
            upper = 1'b1;
            idx   = int'(cp - LAT_A_UP);
         end
      end else begin
         folded = cp;
         if (cp >= CYR_A_UP && cp <= CYR_YA_UP) begin
            upper  = 1'b1;
            folded = cp + CYR_CASE;
         end else if (cp == CYR_IO_UP) begin
            upper  = 1'b1;
            folded = CYR_IO_LO;
         end
         if (folded >= CYR_A_LO && folded <= CYR_IE_LO)
            idx = int'(folded - CYR_A_LO);
         else if (folded == CYR_IO_LO)
            idx = IO_SLOT;
         else if (folded >= CYR_ZH_LO && folded <= CYR_YA_LO)
            idx = int'(folded - CYR_A_LO) + 1;
      end
      if (idx >= 0) begin
         // length 0 behaves as 1, anything above the maximum as the maximum
         len = int'(cfg_key_length);
         if (len < 1) len = 1;
         if (len > MAX_KEY_LENGTH) len = MAX_KEY_LENGTH;
         kp    = int'(key_pos);
         shift = int'(cfg_key_words[(kp / KEYS_PER_WORD) % KEY_WORDS]
                                   [(kp % KEYS_PER_WORD) * KEY_W +: KEY_W]) % size;
         if (!cfg_decrypt)
            res = letter_code((idx + shift) % size, cfg_russian, upper);
         else
            res = letter_code((idx + size - shift) % size, cfg_russian, upper);
         // a key shortened mid-message wraps on the next advance
         kp = kp + 1;
         key_pos = (kp >= len) ? '0 : KEY_W'(kp);
      end
      if (last)
         key_pos = '0;
      return res;
   endfunction

   function automatic logic [KEY_WORD_W-1:0] random_word();
      return KEY_WORD_W'({$urandom, $urandom});
   endfunction

   // Mostly letters of the active alphabet, some foreign letters, neighbors and noise.
   function automatic logic [CP_W-1:0] random_char(input logic russian);
      int   pick;
      logic upper;
      pick  = $urandom_range(0, 99);
      upper = 1'($urandom_range(0, 1));
      if (pick < 70)
         return letter_code($urandom_range(0, russian ? CYR_SIZE - 1 : LAT_SIZE - 1),
                            russian, upper);
      if (pick < 78)
         return letter_code($urandom_range(0, russian ? LAT_SIZE - 1 : CYR_SIZE - 1),
                            !russian, upper);
      if (pick < 86)
         return CP_W'($urandom_range(0, 16'h7F));
      if (pick < 93)
         return CP_W'($urandom_range(16'h3F0, 16'h46F));
      return CP_W'($urandom_range(0, 21'h1FFFFF));
   endfunction

   // Driver: presents queued items, waits a drawn gap before each next one.
   always @(posedge clock) begin : req_drive
      char_item_type item;
      char_item_type want;
      logic          slot_free;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         req_wait   <= 0;
      end else begin
         slot_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            want.code_point = cipher_char(req_tdata[CP_W-1:0], req_tlast);
            want.last       = req_tlast;
            expected_chars.push_back(want);
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (req_wait != 0) begin
               req_wait   <= req_wait - 1;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
               item = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(CP_BYTES_W - CP_W){1'b0}}, item.code_point};
               req_tlast  <= item.last;
               req_wait   <= steady ? 0 : $urandom_range(0, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result against the oldest expectation, stalls at random.
   always @(posedge clock) begin : rsp_check
      char_item_type want;
      int            hold_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         hold_next = rsp_hold;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected rsp item: out_code_point %h out_last %b",
                      rsp_tdata[CP_W-1:0], rsp_tlast);
               failures++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata[CP_W-1:0] !== want.code_point) begin
                  $error("out_code_point: expected %h, got %h",
                         want.code_point, rsp_tdata[CP_W-1:0]);
                  failures++;
               end
               if (rsp_tdata[CP_BYTES_W-1:CP_W] !== '0) begin
                  $error("rsp_tdata pad: expected %h, got %h",
                         {(CP_BYTES_W - CP_W){1'b0}}, rsp_tdata[CP_BYTES_W-1:CP_W]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("out_last: expected %b, got %b", want.last, rsp_tlast);
                  failures++;
               end
            end
            hold_next = steady ? 0 : $urandom_range(0, 7);
         end
         if (hold_next != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= hold_next - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= 0;
         end
      end
   end

   // Register write; mirrors the block's masking into the predictor copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [KEY_WORD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DIRECTION:  cfg_decrypt = value[0];
         CSR_LANGUAGE:   cfg_russian = value[0];
         CSR_KEY_LENGTH: cfg_key_length = value[KEY_W-1:0];
         CSR_KEY_WORD_0: cfg_key_words[0] = value;
         CSR_KEY_WORD_1: cfg_key_words[1] = value;
         CSR_KEY_WORD_2: cfg_key_words[2] = value;
         CSR_KEY_WORD_3: cfg_key_words[3] = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic send(input logic [CP_W-1:0] cp, input logic last);
      char_item_type item;
      item.code_point = cp;
      item.last       = last;
      pending_chars.push_back(item);
   endtask

   // Sender holds off until every result is back, then a few settle cycles.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_tvalid || expected_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [KEY_WORD_W-1:0] len_value;
      int                    len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: English, encrypt, one zero key letter -> letters unchanged.
      send(LAT_A_LO, 1'b0);
      send(LAT_Z_UP, 1'b0);
      send(21'h1FFFFF, 1'b0);     // beyond U+10FFFF passes through
      send(21'h110000, 1'b0);
      send(21'h000000, 1'b1);
      wait_idle();

      // English encrypt, three key letters; 63 reduces modulo 26.
      write_reg(CSR_DIRECTION, '0);
      write_reg(CSR_LANGUAGE, '0);
      write_reg(CSR_KEY_LENGTH, KEY_WORD_W'(3));
      write_reg(CSR_KEY_WORD_0, {42'd0, 6'd25, 6'd63, 6'd1});
      send(LAT_A_LO, 1'b0);
      send(LAT_Z_LO, 1'b0);
      send(LAT_A_UP, 1'b0);
      send(LAT_Z_UP, 1'b0);
      send(LAT_A_UP - 1, 1'b0);   // neighbors of the letter ranges pass through
      send(LAT_Z_UP + 1, 1'b0);
      send(LAT_A_LO - 1, 1'b0);
      send(LAT_Z_LO + 1, 1'b1);
      wait_idle();

      // Russian decrypt, key length 0 acts as 1; io and IO, edges of both cases.
      write_reg(CSR_DIRECTION, KEY_WORD_W'(1));
      write_reg(CSR_LANGUAGE, KEY_WORD_W'(1));
      write_reg(CSR_KEY_LENGTH, '0);
      write_reg(CSR_KEY_WORD_0, {54'd0, 6'd32});
      write_reg(CSR_UNUSED_INDEX, '1);
      send(CYR_A_LO, 1'b0);
      send(CYR_IE_LO, 1'b0);
      send(CYR_IO_LO, 1'b0);
      send(CYR_ZH_LO, 1'b0);
      send(CYR_YA_LO, 1'b0);
      send(CYR_A_UP, 1'b0);
      send(CYR_IO_UP, 1'b0);
      send(CYR_YA_UP, 1'b0);
      send(21'h400, 1'b0);        // near io but not a letter
      send(21'h450, 1'b0);
      send(LAT_Z_LO, 1'b1);       // Latin letter is foreign here
      wait_idle();

      // Random phases. Messages run across phases, so changing key_length with a
      // message open covers the shortened-key wrap; phase 1 forces it after 40.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_reg(CSR_DIRECTION, random_word());
         write_reg(CSR_LANGUAGE, random_word());
         case ($urandom_range(0, 5))
            0:       len = 0;
            1:       len = 1;
            2:       len = MAX_KEY_LENGTH;
            3:       len = 63;
            default: len = $urandom_range(1, MAX_KEY_LENGTH);
         endcase
         if (ph == 0) len = 63;
         if (ph == 1) len = 2;
         len_value = random_word();
         len_value[KEY_W-1:0] = KEY_W'(len);
         write_reg(CSR_KEY_LENGTH, len_value);
         if (ph == 0) begin
            write_reg(CSR_KEY_WORD_0, '1);
            write_reg(CSR_KEY_WORD_1, '1);
            write_reg(CSR_KEY_WORD_2, '1);
            write_reg(CSR_KEY_WORD_3, '1);
         end else if (ph % 3 == 1) begin
            write_reg(CSR_KEY_WORD_0, random_word());
            write_reg(CSR_KEY_WORD_1, random_word());
            write_reg(CSR_KEY_WORD_2, random_word());
            write_reg(CSR_KEY_WORD_3, random_word());
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_UNUSED_INDEX, random_word());
         steady = (ph % 4 == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send(random_char(cfg_russian), $urandom_range(0, 9) == 0);
         wait_idle();
      end

      if (failures == 0)
         $display("vigenere_char_cipher_unit test passed");
      else
         $display("vigenere_char_cipher_unit test failed");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 12);
      $display("vigenere_char_cipher_unit test failed");
      $finish;
   end

endmodule
